// ===== hw/rtl/ttct_pkg.sv =====
// Shared types and constants for the triple target-compare timer block.
// Used by ttct_step_unit and triple_target_compare_timer_unit; no dependencies.
`default_nettype none

package ttct_pkg;

    // Item kinds carried in the input tuser field.
    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    // Register selects within one timer's address window.
    localparam logic [3:0] REG_COUNT  = 4'h0;
    localparam logic [3:0] REG_MODE   = 4'h4;
    localparam logic [3:0] REG_TARGET = 4'h8;

    // Mode word bit positions.
    localparam int MODE_RESET_ON_TARGET = 3;
    localparam int MODE_IRQ_ON_TARGET   = 4;
    localparam int MODE_IRQ_ON_WRAP     = 5;
    localparam int MODE_IRQ_REPEAT      = 6;
    localparam int MODE_SRC_LO          = 8;
    localparam int MODE_SRC_HI          = 9;

    // Status bits merged into a mode read.
    localparam logic [15:0] STATUS_TARGET_BIT = 16'h0800;
    localparam logic [15:0] STATUS_WRAP_BIT   = 16'h1000;

    // Clock source codes.
    localparam logic [1:0] SRC_SYS    = 2'd0;
    localparam logic [1:0] SRC_STROBE = 2'd1;

    // Per-timer status flags.
    typedef struct packed {
        logic target_hit;
        logic wrap_hit;
        logic irq_done;
    } tmr_flags_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCESS,
        ST_LOAD,
        ST_STEP,
        ST_NEXT,
        ST_DONE
    } seq_state_t;

endpackage : ttct_pkg

`default_nettype wire

// ===== hw/rtl/ttct_step_unit.sv =====
// One counting step of a timer: increment, target compare, wrap check, interrupt.
// Depends on ttct_pkg for the mode bit positions and the flag struct.
`default_nettype none

module ttct_step_unit
    import ttct_pkg::*;
(
    input  wire logic [15:0] count_in,
    input  wire logic [15:0] target_in,
    input  wire logic [15:0] mode_in,
    input  wire tmr_flags_t  flags_in,
    output logic [15:0]      count_next,
    output tmr_flags_t       flags_next,
    output logic             fired
);

    logic [15:0] count_inc;
    logic        wrapped;
    logic        match;
    logic        rep;
    logic        tgt_arm;
    logic        wrap_arm;
    logic        done_mid;
    logic        fire_tgt;
    logic        fire_wrap;

    // Increment and compare against the target; a zero target never matches.
    always_comb begin
        count_inc = count_in + 16'd1;
        wrapped   = (count_in == 16'hFFFF);
        match     = (target_in != 16'd0) && (count_inc == target_in);
        rep       = mode_in[MODE_IRQ_REPEAT];
        tgt_arm   = match && mode_in[MODE_IRQ_ON_TARGET];
        wrap_arm  = wrapped && mode_in[MODE_IRQ_ON_WRAP];
    end

    // The target event is resolved first, so it can use up a one-shot interrupt.
    always_comb begin
        fire_tgt  = tgt_arm && (!flags_in.irq_done || rep);
        done_mid  = flags_in.irq_done || tgt_arm;
        fire_wrap = wrap_arm && (!done_mid || rep);
        fired     = fire_tgt || fire_wrap;

        flags_next.target_hit = flags_in.target_hit || match;
        flags_next.wrap_hit   = flags_in.wrap_hit || wrapped;
        flags_next.irq_done   = done_mid || wrap_arm;

        if (match && mode_in[MODE_RESET_ON_TARGET]) begin
            count_next = 16'd0;
        end else begin
            count_next = count_inc;
        end
    end

endmodule : ttct_step_unit

`default_nettype wire

// ===== hw/rtl/triple_target_compare_timer_unit.sv =====
// Top level of the triple target-compare timer block: registers, sequencer, result stage.
// Depends on ttct_pkg and instantiates ttct_step_unit.
`default_nettype none

// A register read or write passes through the access and done states to the result.
// A tick walks the timers one after another and runs one counting step per
// cycle through a single shared step unit. Steps per timer: sys_cycles (saturated
// at MAX_TICK_CYCLES) on the system clock, its strobe (dotclock for timer 0, hblank
// for timer 1) on the strobe source, else zero; timer 2 takes sys_cycles/8 on
// sources 2 and 3 and sys_cycles otherwise. The block takes no new transaction
// while an item is in work; a finished result waits in the output register, and
// the next item waits in its done state until that register is free or draining.
module triple_target_compare_timer_unit
    import ttct_pkg::*;
#(
    parameter int NUM_TIMERS      = 3,
    parameter int MAX_TICK_CYCLES = 255
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [5:0] bus_offset, [21:6] write_data, [29:22] sys_cycles, [30] hblank, [31] dotclock
    input  wire logic [31:0] s_tdata,
    // [1:0] mode (item kind)
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [15:0] read_data, [18:16] irq_bits, [23:19] zero
    output logic [23:0]      m_tdata
);

    localparam int TW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam logic [7:0] SYS_LIMIT =
        (MAX_TICK_CYCLES >= 255) ? 8'hFF : 8'(MAX_TICK_CYCLES);
    localparam logic [1:0] LAST_TIMER = 2'(NUM_TIMERS - 1);
    localparam logic [2:0] TIMER_COUNT = 3'(NUM_TIMERS);

    // Timer state.
    logic [15:0] count_reg  [NUM_TIMERS];
    logic [15:0] target_reg [NUM_TIMERS];
    logic [15:0] mode_reg   [NUM_TIMERS];
    tmr_flags_t  flags_reg  [NUM_TIMERS];

    // Latched item and work registers.
    seq_state_t  state_reg, state_next;
    logic [1:0]  kind_reg;
    logic [3:0]  regsel_reg;
    logic [15:0] wdata_reg;
    logic [7:0]  sys_reg;
    logic        hblank_reg;
    logic        dotclock_reg;
    logic [1:0]  timer_reg;
    logic [7:0]  steps_reg, steps_next;
    logic [15:0] rdata_reg;
    logic [2:0]  irq_reg;
    logic        m_valid_reg;
    logic [23:0] m_data_reg;

    // Control decoded from the sequencer state.
    logic        accept;
    logic        do_access;
    logic        do_load;
    logic        do_step;
    logic        do_next;
    logic        load_result;

    logic [TW-1:0] tix;
    logic          timer_ok;
    logic          last_step;
    logic [7:0]    sys_sat;
    logic [1:0]    src;

    logic [15:0] step_count;
    tmr_flags_t  step_flags;
    logic        step_fired;

    assign tix      = timer_reg[TW-1:0];
    assign timer_ok = ({1'b0, timer_reg} < TIMER_COUNT);
    assign sys_sat  = (s_tdata[29:22] > SYS_LIMIT) ? SYS_LIMIT : s_tdata[29:22];
    assign src      = mode_reg[tix][MODE_SRC_HI:MODE_SRC_LO];
    assign last_step = (steps_reg == 8'd1);

    // Shared step unit, applied to the timer under the sequencer.
    ttct_step_unit u_step (
        .count_in   (count_reg[tix]),
        .target_in  (target_reg[tix]),
        .mode_in    (mode_reg[tix]),
        .flags_in   (flags_reg[tix]),
        .count_next (step_count),
        .flags_next (step_flags),
        .fired      (step_fired)
    );

    // Number of steps for the current timer from its clock source.
    always_comb begin
        if (timer_reg == 2'd0) begin
            if (src == SRC_STROBE) begin
                steps_next = {7'd0, dotclock_reg};
            end else if (src == SRC_SYS) begin
                steps_next = sys_reg;
            end else begin
                steps_next = 8'd0;
            end
        end else if (timer_reg == 2'd1) begin
            if (src == SRC_STROBE) begin
                steps_next = {7'd0, hblank_reg};
            end else if (src == SRC_SYS) begin
                steps_next = sys_reg;
            end else begin
                steps_next = 8'd0;
            end
        end else if (src inside {2'd2, 2'd3}) begin
            steps_next = {3'd0, sys_reg[7:3]};
        end else begin
            steps_next = sys_reg;
        end
    end

    // Sequencer next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = (s_tuser == KIND_TICK) ? ST_LOAD : ST_ACCESS;
                end
            end
            ST_ACCESS: state_next = ST_DONE;
            ST_LOAD: begin
                state_next = (steps_next != 8'd0) ? ST_STEP : ST_NEXT;
            end
            ST_STEP: begin
                if (last_step) begin
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT: begin
                state_next = (timer_reg == LAST_TIMER) ? ST_DONE : ST_LOAD;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        s_tready    = 1'b0;
        do_access   = 1'b0;
        do_load     = 1'b0;
        do_step     = 1'b0;
        do_next     = 1'b0;
        load_result = 1'b0;
        case (state_reg)
            ST_IDLE:   s_tready = 1'b1;
            ST_ACCESS: do_access = 1'b1;
            ST_LOAD:   do_load = 1'b1;
            ST_STEP:   do_step = 1'b1;
            ST_NEXT:   do_next = (timer_reg != LAST_TIMER);
            ST_DONE:   load_result = !m_valid_reg || m_tready;
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign accept = s_tvalid && s_tready;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Item latch and work registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg     <= s_tuser;
            regsel_reg   <= s_tdata[3:0];
            wdata_reg    <= s_tdata[21:6];
            sys_reg      <= sys_sat;
            hblank_reg   <= s_tdata[30];
            dotclock_reg <= s_tdata[31];
            timer_reg    <= (s_tuser == KIND_TICK) ? 2'd0 : s_tdata[5:4];
            rdata_reg    <= 16'd0;
            irq_reg      <= 3'd0;
        end
        if (do_load) begin
            steps_reg <= steps_next;
        end
        if (do_step) begin
            steps_reg <= steps_reg - 8'd1;
            if (step_fired) begin
                irq_reg <= irq_reg | (3'b001 << timer_reg);
            end
        end
        if (do_next) begin
            timer_reg <= timer_reg + 2'd1;
        end
        // Register read, answered from the addressed timer.
        if (do_access && kind_reg == KIND_READ && timer_ok) begin
            case (regsel_reg)
                REG_COUNT:  rdata_reg <= count_reg[tix];
                REG_MODE: begin
                    rdata_reg <= mode_reg[tix]
                               | (flags_reg[tix].target_hit ? STATUS_TARGET_BIT : 16'd0)
                               | (flags_reg[tix].wrap_hit ? STATUS_WRAP_BIT : 16'd0);
                end
                REG_TARGET: rdata_reg <= target_reg[tix];
                default:    rdata_reg <= 16'd0;
            endcase
        end
    end

    // Timer registers: bus writes and counting steps.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_TIMERS; i++) begin
                count_reg[i]  <= 16'd0;
                target_reg[i] <= 16'd0;
                mode_reg[i]   <= 16'd0;
                flags_reg[i]  <= '0;
            end
        end else if (do_access && kind_reg == KIND_WRITE && timer_ok) begin
            case (regsel_reg)
                REG_COUNT: count_reg[tix] <= wdata_reg;
                REG_MODE: begin
                    // A mode write restarts the timer and clears its status.
                    mode_reg[tix]  <= wdata_reg;
                    count_reg[tix] <= 16'd0;
                    flags_reg[tix] <= '0;
                end
                REG_TARGET: target_reg[tix] <= wdata_reg;
                default: begin
                    count_reg[tix] <= count_reg[tix];
                end
            endcase
        end else if (do_step) begin
            count_reg[tix] <= step_count;
            flags_reg[tix] <= step_flags;
        end
    end

    // Output register holding one result transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_result) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_result) begin
            m_data_reg <= {5'd0, irq_reg, rdata_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // A step is only run with steps left to take.
    a_step_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_STEP |-> steps_reg != 8'd0)
        else $error("step state entered with no steps left");

    // The tick walk never addresses a timer that is not present.
    a_load_timer_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOAD || state_reg == ST_STEP) |-> timer_ok)
        else $error("tick addresses a missing timer");

    // A new result is only loaded when the output register is free or draining.
    a_result_room: assert property (@(posedge aclk) disable iff (!aresetn)
        load_result |-> (!m_valid_reg || m_tready))
        else $error("result overwrites a pending transaction");

    // An accepted item keeps the block busy for the following cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("input ready right after an accepted transaction");

endmodule : triple_target_compare_timer_unit

`default_nettype wire
